/* design/llt_pkg.sv */
// Shared constants, types and arithmetic helpers for the lat/long to tile block.
// Depends on nothing; every other file in design/ refers to it by scoped names.
package llt_pkg;

    localparam int COORD_FRAC_BITS = 22;
    localparam int DEPTH_CAP       = 23;

    localparam int LON_W   = 31;
    localparam int LAT_W   = 30;
    localparam int DEPTH_W = 5;
    localparam int TILE_W  = 23;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 56;

    // Pipeline: five grid stages, two tile stages.
    localparam int NSTAGE      = 7;
    localparam int GRID_STAGES = 5;

    // Half ranges in fixed point; full range is 45 * 2^(F+3) for longitude
    // and 45 * 2^(F+2) for latitude.
    localparam int HALF_LON = 180 << COORD_FRAC_BITS;
    localparam int HALF_LAT = 90 << COORD_FRAC_BITS;
    localparam int LON_G    = 32;
    localparam int LAT_G    = 31;
    localparam int LON_S    = COORD_FRAC_BITS + 3;
    localparam int LAT_S    = COORD_FRAC_BITS + 2;

    localparam int OFF_W = 31;
    localparam int QA_W  = 26;
    localparam int REM_W = 6;
    localparam int T_W   = QA_W + LON_G;
    localparam int TH_W  = 34;
    localparam int TL_W  = LON_S;
    localparam int W_W   = 38;
    localparam int V_W   = 13;
    localparam int SM_W  = 14;
    localparam int GX_W  = 32;
    localparam int QE_W  = 24;
    localparam int QT_W  = 25;
    localparam int K_W   = 6;
    localparam int SH_W  = 8;
    localparam int R_W   = 34;

    localparam int DIV45 = 45;

    // floor(n/45) = (n * ceil(2^37/45)) >> 37 for n < 2^31
    localparam logic [31:0] DIV45_MUL   = 32'd3054198967;
    localparam int          DIV45_SHIFT = 37;
    // floor(v/45) = (v * ceil(2^19/45)) >> 19 for v < 2^13
    localparam logic [SM_W-1:0] SMALL45_MUL   = 14'd11651;
    localparam int              SMALL45_SHIFT = 19;

    typedef logic [GX_W-1:0]    grid_t;
    typedef logic [TILE_W-1:0]  tile_t;
    typedef logic [DEPTH_W-1:0] depth_t;
    typedef logic [K_W-1:0]     kshift_t;

    typedef struct packed {
        logic [NSTAGE-1:0] load;
    } llt_ctl_t;

    // Saturate a coordinate to [-half, +half] and move it to [0, 2*half].
    function automatic logic [OFF_W-1:0] coord_offset(input logic signed [32:0] c,
                                                      input logic signed [32:0] half);
        logic signed [32:0] cs;
        cs = c;
        if (cs < -half)
            cs = -half;
        else if (cs > half)
            cs = half;
        return OFF_W'(cs + half);
    endfunction

    function automatic logic [QA_W-1:0] div45(input logic [OFF_W-1:0] n);
        logic [OFF_W+31:0] p;
        p = (OFF_W+32)'(n) * (OFF_W+32)'(DIV45_MUL);
        return QA_W'(p >> DIV45_SHIFT);
    endfunction

    function automatic logic [REM_W-1:0] rem45(input logic [OFF_W-1:0] n,
                                               input logic [QA_W-1:0] a);
        logic [OFF_W-1:0] t;
        t = n - OFF_W'(a) * OFF_W'(DIV45);
        return REM_W'(t);
    endfunction

    // a * (2^g - 1) split at bit s
    function automatic logic [TH_W-1:0] hi_part(input logic [QA_W-1:0] a,
                                                input int g, input int s);
        logic [T_W-1:0] t;
        t = (T_W'(a) << g) - T_W'(a);
        return TH_W'(t >> s);
    endfunction

    function automatic logic [TL_W-1:0] lo_part(input logic [QA_W-1:0] a,
                                                input int g, input int s);
        logic [T_W-1:0] t;
        t = (T_W'(a) << g) - T_W'(a);
        return TL_W'(t & ((T_W'(1) << s) - T_W'(1)));
    endfunction

    // floor((45*tl + b*(2^g-1)) / 2^s), still to be divided by 45
    function automatic logic [V_W-1:0] fold_rem(input logic [TL_W-1:0] tl,
                                                input logic [REM_W-1:0] b,
                                                input int g, input int s);
        logic [W_W-1:0] w;
        w = W_W'(tl) * W_W'(DIV45) + (W_W'(b) << g) - W_W'(b);
        return V_W'(w >> s);
    endfunction

    function automatic grid_t grid_sum(input logic [TH_W-1:0] th,
                                       input logic [V_W-1:0] v);
        logic [V_W+SM_W-1:0] p;
        logic [TH_W-1:0]     s;
        p = (V_W+SM_W)'(v) * (V_W+SM_W)'(SMALL45_MUL);
        s = th + TH_W'(p >> SMALL45_SHIFT);
        return GX_W'(s);
    endfunction

endpackage

/* design/llt_ctrl.sv */
// Valid bits and per-stage load enables for the seven-stage pipeline.
// Depends on llt_pkg.
module llt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output llt_pkg::llt_ctl_t ctl
);

    logic [llt_pkg::NSTAGE-1:0] valid_reg;
    logic [llt_pkg::NSTAGE-1:0] valid_next;
    logic [llt_pkg::NSTAGE-1:0] load;

    // A stage loads when it is empty or its content moves on.
    always_comb
    begin
        load[llt_pkg::NSTAGE-1] = !valid_reg[llt_pkg::NSTAGE-1] || out_ready;
        for (int i = llt_pkg::NSTAGE - 2; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    always_comb
    begin
        valid_next[0] = load[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < llt_pkg::NSTAGE; i++)
        begin
            valid_next[i] = load[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign ctl.load  = load;
    assign in_ready  = load[0];
    assign out_valid = valid_reg[llt_pkg::NSTAGE-1];

endmodule

/* design/llt_grid.sv */
// Five-stage mapping of saturated longitude and latitude onto the unit grid.
// Depends on llt_pkg.
module llt_grid (
    input  logic                              clk,
    input  llt_pkg::llt_ctl_t                 ctl,
    input  logic signed [llt_pkg::LON_W-1:0]  longitude_fx,
    input  logic signed [llt_pkg::LAT_W-1:0]  latitude_fx,
    input  llt_pkg::depth_t                   depth,
    output llt_pkg::grid_t                    grid_lon,
    output llt_pkg::grid_t                    grid_lat,
    output llt_pkg::depth_t                   grid_depth
);

    // stage 0: saturate and offset
    logic [llt_pkg::OFF_W-1:0] off_lon_reg, off_lon_next;
    logic [llt_pkg::OFF_W-1:0] off_lat_reg, off_lat_next;
    llt_pkg::depth_t           d0_reg, d0_next;
    // stage 1: quotient by 45
    logic [llt_pkg::OFF_W-1:0] off1_lon_reg, off1_lat_reg;
    logic [llt_pkg::QA_W-1:0]  a_lon_reg, a_lon_next;
    logic [llt_pkg::QA_W-1:0]  a_lat_reg, a_lat_next;
    llt_pkg::depth_t           d1_reg;
    // stage 2: remainder and scaled quotient
    logic [llt_pkg::TH_W-1:0]  th_lon_reg, th_lon_next, th_lat_reg, th_lat_next;
    logic [llt_pkg::TL_W-1:0]  tl_lon_reg, tl_lon_next, tl_lat_reg, tl_lat_next;
    logic [llt_pkg::REM_W-1:0] b_lon_reg, b_lon_next, b_lat_reg, b_lat_next;
    llt_pkg::depth_t           d2_reg;
    // stage 3: fold the low part
    logic [llt_pkg::TH_W-1:0]  th3_lon_reg, th3_lat_reg;
    logic [llt_pkg::V_W-1:0]   v_lon_reg, v_lon_next, v_lat_reg, v_lat_next;
    llt_pkg::depth_t           d3_reg;
    // stage 4: grid words
    llt_pkg::grid_t            x_lon_reg, x_lon_next, x_lat_reg, x_lat_next;
    llt_pkg::depth_t           d4_reg;

    always_comb
    begin
        off_lon_next = llt_pkg::coord_offset(33'(longitude_fx), 33'(llt_pkg::HALF_LON));
        off_lat_next = llt_pkg::coord_offset(33'(latitude_fx), 33'(llt_pkg::HALF_LAT));
        d0_next      = (depth > llt_pkg::DEPTH_W'(llt_pkg::DEPTH_CAP)) ?
                       llt_pkg::DEPTH_W'(llt_pkg::DEPTH_CAP) : depth;

        a_lon_next = llt_pkg::div45(off_lon_reg);
        a_lat_next = llt_pkg::div45(off_lat_reg);

        b_lon_next  = llt_pkg::rem45(off1_lon_reg, a_lon_reg);
        b_lat_next  = llt_pkg::rem45(off1_lat_reg, a_lat_reg);
        th_lon_next = llt_pkg::hi_part(a_lon_reg, llt_pkg::LON_G, llt_pkg::LON_S);
        th_lat_next = llt_pkg::hi_part(a_lat_reg, llt_pkg::LAT_G, llt_pkg::LAT_S);
        tl_lon_next = llt_pkg::lo_part(a_lon_reg, llt_pkg::LON_G, llt_pkg::LON_S);
        tl_lat_next = llt_pkg::lo_part(a_lat_reg, llt_pkg::LAT_G, llt_pkg::LAT_S);

        v_lon_next = llt_pkg::fold_rem(tl_lon_reg, b_lon_reg, llt_pkg::LON_G, llt_pkg::LON_S);
        v_lat_next = llt_pkg::fold_rem(tl_lat_reg, b_lat_reg, llt_pkg::LAT_G, llt_pkg::LAT_S);

        x_lon_next = llt_pkg::grid_sum(th3_lon_reg, v_lon_reg);
        x_lat_next = llt_pkg::grid_sum(th3_lat_reg, v_lat_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            off_lon_reg <= off_lon_next;
            off_lat_reg <= off_lat_next;
            d0_reg      <= d0_next;
        end
        if (ctl.load[1])
        begin
            off1_lon_reg <= off_lon_reg;
            off1_lat_reg <= off_lat_reg;
            a_lon_reg    <= a_lon_next;
            a_lat_reg    <= a_lat_next;
            d1_reg       <= d0_reg;
        end
        if (ctl.load[2])
        begin
            th_lon_reg <= th_lon_next;
            th_lat_reg <= th_lat_next;
            tl_lon_reg <= tl_lon_next;
            tl_lat_reg <= tl_lat_next;
            b_lon_reg  <= b_lon_next;
            b_lat_reg  <= b_lat_next;
            d2_reg     <= d1_reg;
        end
        if (ctl.load[3])
        begin
            th3_lon_reg <= th_lon_reg;
            th3_lat_reg <= th_lat_reg;
            v_lon_reg   <= v_lon_next;
            v_lat_reg   <= v_lat_next;
            d3_reg      <= d2_reg;
        end
        if (ctl.load[4])
        begin
            x_lon_reg <= x_lon_next;
            x_lat_reg <= x_lat_next;
            d4_reg    <= d3_reg;
        end
    end

    assign grid_lon   = x_lon_reg;
    assign grid_lat   = x_lat_reg;
    assign grid_depth = d4_reg;

endmodule

/* design/llt_tile.sv */
// Two-stage division of a grid word by the step 2^k - 1, clamped to the tile limit.
// Depends on llt_pkg.
module llt_tile (
    input  logic              clk,
    input  llt_pkg::llt_ctl_t ctl,
    input  llt_pkg::grid_t    grid,
    input  llt_pkg::kshift_t  kshift,
    input  llt_pkg::depth_t   depth,
    output llt_pkg::tile_t    tile
);

    llt_pkg::grid_t           x_reg;
    llt_pkg::kshift_t         k_reg;
    logic [llt_pkg::QE_W-1:0] qe_reg, qe_next;
    logic [llt_pkg::R_W-1:0]  step_reg, step_next;
    logic [llt_pkg::R_W-1:0]  step2_reg, step2_next;
    logic [llt_pkg::R_W-1:0]  step3_reg, step3_next;
    llt_pkg::tile_t           lim_reg, lim_next;
    llt_pkg::tile_t           tile_reg, tile_next;

    logic [llt_pkg::SH_W-1:0]   k2, k3;
    logic [llt_pkg::TILE_W:0]   lim_w;
    logic [llt_pkg::R_W-1:0]    prod, rem;
    logic [1:0]                 fix;
    logic [llt_pkg::QT_W-1:0]   q;

    // Estimate x/(2^k-1) from the series x>>k + x>>2k + x>>3k; short by at most 3.
    always_comb
    begin
        k2         = llt_pkg::SH_W'(kshift) << 1;
        k3         = k2 + llt_pkg::SH_W'(kshift);
        qe_next    = llt_pkg::QE_W'((grid >> kshift) + (grid >> k2) + (grid >> k3));
        step_next  = (llt_pkg::R_W'(1) << kshift) - llt_pkg::R_W'(1);
        step2_next = step_next << 1;
        step3_next = step2_next + step_next;
        lim_w      = ((llt_pkg::TILE_W+1)'(1) << depth) - (llt_pkg::TILE_W+1)'(1);
        lim_next   = llt_pkg::TILE_W'(lim_w);
    end

    // Correct the estimate from the remainder, then clamp.
    always_comb
    begin
        prod = (llt_pkg::R_W'(qe_reg) << k_reg) - llt_pkg::R_W'(qe_reg);
        rem  = llt_pkg::R_W'(x_reg) - prod;
        fix  = {1'b0, rem >= step_reg} + {1'b0, rem >= step2_reg} + {1'b0, rem >= step3_reg};
        q    = llt_pkg::QT_W'(qe_reg) + llt_pkg::QT_W'(fix);
        tile_next = (q > llt_pkg::QT_W'(lim_reg)) ? lim_reg : llt_pkg::TILE_W'(q);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[llt_pkg::GRID_STAGES])
        begin
            x_reg     <= grid;
            k_reg     <= kshift;
            qe_reg    <= qe_next;
            step_reg  <= step_next;
            step2_reg <= step2_next;
            step3_reg <= step3_next;
            lim_reg   <= lim_next;
        end
        if (ctl.load[llt_pkg::GRID_STAGES+1])
            tile_reg <= tile_next;
    end

    assign tile = tile_reg;

endmodule

/* design/lat_long_to_tile_row_col.sv */
// Each accepted input item runs through the grid stages, then the tile stages.
// Throughput: one item per cycle when not stalled; the /45 reciprocal multiply
// and the step correction each have their own register stages, so nothing loops.
// Back-pressure holds the output register and collapses bubbles upstream.
// Reset (rst_n, asynchronous, active low) clears the stage valid bits only.
// Top level of the lat/long tile lookup; uses llt_pkg, llt_ctrl, llt_grid, llt_tile.
module lat_long_to_tile_row_col (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [30:0] longitude_fx, [60:31] latitude_fx, [65:61] depth, [71:66] zero
    input  logic [llt_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [22:0] tile_row, [45:23] tile_col, [50:46] tile_depth, [55:51] zero
    output logic [llt_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    llt_pkg::llt_ctl_t ctl;

    logic signed [llt_pkg::LON_W-1:0] longitude_fx;
    logic signed [llt_pkg::LAT_W-1:0] latitude_fx;
    llt_pkg::depth_t                  depth;

    llt_pkg::grid_t   grid_lon, grid_lat;
    llt_pkg::depth_t  grid_depth;
    llt_pkg::kshift_t k_lon, k_lat;
    llt_pkg::tile_t   tile_row, tile_col;

    // Depth rides alongside the two tile stages.
    llt_pkg::depth_t  d5_reg, d6_reg;

    // Unpack the input item.
    assign longitude_fx = s_tdata[30:0];
    assign latitude_fx  = s_tdata[60:31];
    assign depth        = s_tdata[65:61];

    // Pipeline control: one valid bit per stage, load when empty or draining.
    llt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .ctl       (ctl)
    );

    // Stages 0-4: saturate, offset and scale both coordinates onto the
    // 32-bit (longitude) and 31-bit (latitude) unit grids.
    llt_grid u_grid (
        .clk          (clk),
        .ctl          (ctl),
        .longitude_fx (longitude_fx),
        .latitude_fx  (latitude_fx),
        .depth        (depth),
        .grid_lon     (grid_lon),
        .grid_lat     (grid_lat),
        .grid_depth   (grid_depth)
    );

    // Grid step at depth d is 2^(32-d)-1 for longitude, 2^(31-d)-1 for latitude.
    assign k_lon = llt_pkg::K_W'(llt_pkg::LON_G) - llt_pkg::K_W'(grid_depth);
    assign k_lat = llt_pkg::K_W'(llt_pkg::LAT_G) - llt_pkg::K_W'(grid_depth);

    // Stages 5-6: divide by the step and clamp to 2^d - 1.
    llt_tile u_tile_col (
        .clk    (clk),
        .ctl    (ctl),
        .grid   (grid_lon),
        .kshift (k_lon),
        .depth  (grid_depth),
        .tile   (tile_col)
    );

    llt_tile u_tile_row (
        .clk    (clk),
        .ctl    (ctl),
        .grid   (grid_lat),
        .kshift (k_lat),
        .depth  (grid_depth),
        .tile   (tile_row)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.load[llt_pkg::GRID_STAGES])
            d5_reg <= grid_depth;
        if (ctl.load[llt_pkg::GRID_STAGES+1])
            d6_reg <= d5_reg;
    end

    // Pack the result item.
    assign m_tdata = {5'b0, d6_reg, tile_col, tile_row};

`ifndef SYNTHESIS
    // Row and column never exceed the clamp for the returned depth.
    a_tile_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[22:0] >> m_tdata[50:46]) == 23'd0) &&
                     ((m_tdata[45:23] >> m_tdata[50:46]) == 23'd0))
        else $error("tile row or column beyond 2^depth - 1");

    // Returned depth has been saturated.
    a_depth_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[50:46] <= llt_pkg::DEPTH_W'(llt_pkg::DEPTH_CAP)))
        else $error("tile depth above maximum");

    // With the output draining or empty, the whole pipeline advances.
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tready || !m_tvalid) |-> s_tready)
        else $error("input stalled while output is free");
`endif

endmodule

/* tb/tb_lat_long_to_tile_row_col.sv */
// Self-checking testbench for lat_long_to_tile_row_col: streams coordinate items
// with random gaps and back-pressure and checks every tile against a local predictor.
// Depends on llt_pkg and the lat_long_to_tile_row_col RTL in design/.
module tb_lat_long_to_tile_row_col;
    timeunit 1ns;
    timeprecision 1ps;

    typedef longint unsigned u64_t;

    // One expected tile, laid out so that a cast of m_tdata[50:0] lines up.
    typedef struct packed {
        llt_pkg::depth_t depth;
        llt_pkg::tile_t  col;
        llt_pkg::tile_t  row;
    } tile_result_t;

    localparam u64_t LON_SPAN = 64'hffffffff;
    localparam u64_t LAT_SPAN = 64'h7fffffff;

    localparam int LON_HALF = 180 << llt_pkg::COORD_FRAC_BITS;
    localparam int LAT_HALF = 90 << llt_pkg::COORD_FRAC_BITS;

    // Raw field limits, well past the legal coordinate range.
    localparam int LON_FIELD_MIN = -(1 << (llt_pkg::LON_W - 1));
    localparam int LON_FIELD_MAX = (1 << (llt_pkg::LON_W - 1)) - 1;
    localparam int LAT_FIELD_MIN = -(1 << (llt_pkg::LAT_W - 1));
    localparam int LAT_FIELD_MAX = (1 << (llt_pkg::LAT_W - 1)) - 1;

    localparam int TDATA_PAD     = llt_pkg::IN_TDATA_W - llt_pkg::LON_W - llt_pkg::LAT_W
                                   - llt_pkg::DEPTH_W;
    localparam int MAX_GAP       = 19;
    localparam int RESET_CYCLES  = 10;
    localparam int DRAIN_CYCLES  = 30;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 390;
    // Leave plenty of room above the slowest legal run.
    localparam int unsigned CYCLE_LIMIT = 500000;

    // Scoreboard: predicts a tile for every accepted point and checks results
    // in order against the oldest prediction.
    class tile_scoreboard;
        tile_result_t pending[$];
        int           errors;

        function u64_t grid_pos(longint c, longint half, u64_t span);
            longint cs;
            cs = c;
            // saturate to the legal range before moving onto the grid
            if (cs < -half)
                cs = -half;
            if (cs > half)
                cs = half;
            return (u64_t'(cs + half) * span) / (u64_t'(half) * 2);
        endfunction

        function llt_pkg::tile_t tile_index(u64_t g, u64_t span, int unsigned d);
            u64_t step;
            u64_t lim;
            u64_t t;
            step = span >> d;
            lim  = (u64_t'(1) << d) - 1;
            t    = g / step;
            // east and north edges land one past the last tile; clamp them
            if (t > lim)
                t = lim;
            return llt_pkg::tile_t'(t);
        endfunction

        function void note_point(logic [llt_pkg::LON_W-1:0] lon,
                                 logic [llt_pkg::LAT_W-1:0] lat,
                                 logic [llt_pkg::DEPTH_W-1:0] d_raw);
            tile_result_t exp_tile;
            int unsigned  d;
            u64_t         gx;
            u64_t         gy;
            d = 32'(d_raw);
            if (d > llt_pkg::DEPTH_CAP)
                d = llt_pkg::DEPTH_CAP;
            gx = grid_pos(longint'($signed(lon)), longint'(LON_HALF), LON_SPAN);
            gy = grid_pos(longint'($signed(lat)), longint'(LAT_HALF), LAT_SPAN);
            exp_tile.row   = tile_index(gy, LAT_SPAN, d);
            exp_tile.col   = tile_index(gx, LON_SPAN, d);
            exp_tile.depth = llt_pkg::depth_t'(d);
            pending.push_back(exp_tile);
        endfunction

        function void check_tile(logic [llt_pkg::OUT_TDATA_W-1:0] tdata);
            tile_result_t got;
            tile_result_t exp_tile;
            got = tile_result_t'(tdata[$bits(tile_result_t)-1:0]);
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected tile: row %0d col %0d depth %0d",
                             got.row, got.col, got.depth);
                return;
            end
            exp_tile = pending.pop_front();
            if (got.row !== exp_tile.row || got.col !== exp_tile.col ||
                got.depth !== exp_tile.depth)
            begin
                errors++;
                if (errors <= 10)
                    $display({"tile mismatch: expected row %0d col %0d depth %0d, ",
                              "got row %0d col %0d depth %0d"},
                             exp_tile.row, exp_tile.col, exp_tile.depth,
                             got.row, got.col, got.depth);
            end
        endfunction
    endclass

    logic                              clk      = 1'b0;
    logic                              rst_n    = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [llt_pkg::IN_TDATA_W-1:0]    s_tdata  = '0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [llt_pkg::OUT_TDATA_W-1:0]   m_tdata;

    // Idle switches per side; cleared for stretches of back-to-back traffic.
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;

    int unsigned    cycle_count = 0;
    tile_scoreboard sb;

    lat_long_to_tile_row_col dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Drive one point: idle for a random gap, then hold the item until the
    // block takes it. Valid stays high across back-to-back items so it never
    // gets two assignments in one step.
    task automatic send_point(input int lon, input int lat, input int d);
        int unsigned                 gap;
        logic [llt_pkg::LON_W-1:0]   lon_f;
        logic [llt_pkg::LAT_W-1:0]   lat_f;
        logic [llt_pkg::DEPTH_W-1:0] d_f;
        lon_f = llt_pkg::LON_W'(lon);
        lat_f = llt_pkg::LAT_W'(lat);
        d_f   = llt_pkg::DEPTH_W'(d);
        gap   = tx_idle ? $urandom_range(MAX_GAP) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{TDATA_PAD{1'b0}}, d_f, lat_f, lon_f};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_point(lon_f, lat_f, d_f);
    endtask

    // Random coordinate: mostly legal, some raw field noise that saturates,
    // some right at the edges of the legal range.
    function automatic int rand_coord(int half);
        int unsigned pick;
        int          c;
        pick = $urandom_range(99);
        if (pick < 70)
            c = int'($urandom_range(2 * half)) - half;
        else if (pick < 85)
            c = int'($urandom);
        else
            c = ($urandom_range(1) ? half : -half) + int'($urandom_range(8)) - 4;
        return c;
    endfunction

    task automatic send_random_point();
        int d;
        // depths past the maximum saturate; keep them a minority
        if ($urandom_range(99) < 85)
            d = int'($urandom_range(llt_pkg::DEPTH_CAP));
        else
            d = int'($urandom_range(31, llt_pkg::DEPTH_CAP + 1));
        send_point(rand_coord(LON_HALF), rand_coord(LAT_HALF), d);
    endtask

    // Result side: stall for a random number of cycles per item, then check
    // whatever the block hands over.
    initial
    begin
        int unsigned gap;
        wait (rst_n);
        forever
        begin
            gap = rx_idle ? $urandom_range(MAX_GAP) : 0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            sb.check_tile(m_tdata);
        end
    end

    // Watchdog: end the run if it hangs.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_lat_long_to_tile_row_col: FAIL");
        $finish;
    end

    initial
    begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed points: origin, exact edges, field extremes, saturation
        // on both sides, depth extremes and depths past the maximum.
        send_point(0, 0, 0);
        send_point(LON_HALF, LAT_HALF, 0);
        send_point(-LON_HALF, -LAT_HALF, llt_pkg::DEPTH_CAP);
        send_point(LON_HALF, LAT_HALF, llt_pkg::DEPTH_CAP);
        send_point(LON_HALF - 1, LAT_HALF - 1, llt_pkg::DEPTH_CAP);
        send_point(-LON_HALF + 1, -LAT_HALF + 1, llt_pkg::DEPTH_CAP);
        send_point(LON_FIELD_MIN, LAT_FIELD_MIN, 12);
        send_point(LON_FIELD_MAX, LAT_FIELD_MAX, 12);
        send_point(-LON_HALF - 1, LAT_HALF + 1, 5);
        send_point(LON_HALF + 1, -LAT_HALF - 1, 5);
        send_point(LON_FIELD_MAX, LAT_FIELD_MIN, 1);
        send_point(LON_FIELD_MIN, LAT_FIELD_MAX, 1);
        send_point(0, 0, llt_pkg::DEPTH_CAP + 1);
        send_point(LON_HALF, LAT_HALF, 31);
        send_point(-1, -1, 31);
        send_point(1, 1, 1);
        send_point(0, 0, llt_pkg::DEPTH_CAP);
        send_point(-1, -1, llt_pkg::DEPTH_CAP);
        send_point(LON_HALF, -LAT_HALF, 2);
        send_point(-LON_HALF, LAT_HALF, 16);
        send_point(LON_HALF / 2, -LAT_HALF / 2, 22);

        // Random phases; switch the idling per side so back-to-back traffic,
        // one-sided stalls and full idling all get their turn.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                1:
                begin
                    tx_idle = 1'b0;
                    rx_idle = 1'b1;
                end
                2:
                begin
                    tx_idle = 1'b1;
                    rx_idle = 1'b0;
                end
                3:
                begin
                    tx_idle = 1'b0;
                    rx_idle = 1'b0;
                end
                default:
                begin
                    tx_idle = 1'b1;
                    rx_idle = 1'b1;
                end
            endcase
            repeat (PHASE_ITEMS) send_random_point();
        end
        s_tvalid <= 1'b0;

        // Drain: wait for every predicted tile, then keep watching for stray results.
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_lat_long_to_tile_row_col: PASS");
        else
            $display("tb_lat_long_to_tile_row_col: FAIL");
        $finish;
    end

endmodule
